/* hdl/nirtx_pkg.sv */
package nirtx_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_SEND_AC  = 2'd1,
    FUNC_SEND_RAW = 2'd2,
    FUNC_NOP      = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_STOP_MARK  = 3'd5
  } phase_e;

  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLED      = 3'd0,
    REG_LEADER_MARK  = 3'd1,
    REG_LEADER_SPACE = 3'd2,
    REG_BIT_MARK     = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_SPACE    = 3'd5,
    REG_RSVD6        = 3'd6,
    REG_RSVD7        = 3'd7
  } reg_idx_e;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_IN_W = 6;

  localparam logic [DUR_W-1:0] RST_LEADER_MARK  = 16'd9000;
  localparam logic [DUR_W-1:0] RST_LEADER_SPACE = 16'd4500;
  localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd560;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd560;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1690;

  typedef struct packed {
    logic             enabled;
    logic [DUR_W-1:0] leader_mark;
    logic [DUR_W-1:0] leader_space;
    logic [DUR_W-1:0] bit_mark;
    logic [DUR_W-1:0] zero_space;
    logic [DUR_W-1:0] one_space;
  } cfg_t;

  typedef struct packed {
    logic ir_gate;
    logic busy;
    logic frame_done;
    logic rejected;
  } res_t;

  // A zero length still lasts one tick.
  function automatic logic [DUR_W-1:0] len_of(logic [DUR_W-1:0] v);
    return (v == '0) ? DUR_W'(1) : v;
  endfunction

endpackage

/* hdl/nirtx_regs.sv */
module nirtx_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nirtx_pkg::ADDR_W-1:0]  paddr,
  input  logic [nirtx_pkg::DATA_W-1:0]  pwdata,
  output logic [nirtx_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output nirtx_pkg::cfg_t               cfg_o
);

  nirtx_pkg::cfg_t      cfg_q;
  nirtx_pkg::reg_idx_e  idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = nirtx_pkg::reg_idx_e'(paddr[nirtx_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled      <= 1'b0;
      cfg_q.leader_mark  <= nirtx_pkg::RST_LEADER_MARK;
      cfg_q.leader_space <= nirtx_pkg::RST_LEADER_SPACE;
      cfg_q.bit_mark     <= nirtx_pkg::RST_BIT_MARK;
      cfg_q.zero_space   <= nirtx_pkg::RST_ZERO_SPACE;
      cfg_q.one_space    <= nirtx_pkg::RST_ONE_SPACE;
    end else if (wr_en) begin
      unique case (idx)
        nirtx_pkg::REG_ENABLED:      cfg_q.enabled      <= pwdata[0];
        nirtx_pkg::REG_LEADER_MARK:  cfg_q.leader_mark  <= pwdata[nirtx_pkg::DUR_W-1:0];
        nirtx_pkg::REG_LEADER_SPACE: cfg_q.leader_space <= pwdata[nirtx_pkg::DUR_W-1:0];
        nirtx_pkg::REG_BIT_MARK:     cfg_q.bit_mark     <= pwdata[nirtx_pkg::DUR_W-1:0];
        nirtx_pkg::REG_ZERO_SPACE:   cfg_q.zero_space   <= pwdata[nirtx_pkg::DUR_W-1:0];
        nirtx_pkg::REG_ONE_SPACE:    cfg_q.one_space    <= pwdata[nirtx_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      nirtx_pkg::REG_ENABLED:      prdata = nirtx_pkg::DATA_W'(cfg_q.enabled);
      nirtx_pkg::REG_LEADER_MARK:  prdata = nirtx_pkg::DATA_W'(cfg_q.leader_mark);
      nirtx_pkg::REG_LEADER_SPACE: prdata = nirtx_pkg::DATA_W'(cfg_q.leader_space);
      nirtx_pkg::REG_BIT_MARK:     prdata = nirtx_pkg::DATA_W'(cfg_q.bit_mark);
      nirtx_pkg::REG_ZERO_SPACE:   prdata = nirtx_pkg::DATA_W'(cfg_q.zero_space);
      nirtx_pkg::REG_ONE_SPACE:    prdata = nirtx_pkg::DATA_W'(cfg_q.one_space);
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/nirtx_ctrl.sv */
module nirtx_ctrl #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic [1:0]                      func_i,
  input  logic [7:0]                      address_i,
  input  logic [7:0]                      command_i,
  input  logic [nirtx_pkg::WORD_W-1:0]    raw_word_i,
  input  logic [nirtx_pkg::CNT_IN_W-1:0]  bit_count_i,
  input  nirtx_pkg::cfg_t                 cfg_i,
  output nirtx_pkg::res_t                 res_o,
  output logic                            busy_o
);

  localparam int unsigned BL_W = $clog2(FRAME_BITS + 1);
  localparam int unsigned CMP_W = 7;
  localparam logic [BL_W-1:0]  FRAME_CNT = BL_W'(FRAME_BITS);
  localparam logic [CMP_W-1:0] FRAME_CMP = CMP_W'(FRAME_BITS);

  nirtx_pkg::phase_e                 phase_q, phase_d;
  logic [nirtx_pkg::DUR_W-1:0]       ticks_q, ticks_d, ticks_dec;
  logic [nirtx_pkg::WORD_W-1:0]      shift_q, shift_d, ac_word;
  logic [BL_W-1:0]                   bits_q, bits_d, bits_dec, raw_cnt;
  nirtx_pkg::func_e                  func;
  nirtx_pkg::res_t                   res;

  assign func      = nirtx_pkg::func_e'(func_i);
  assign ac_word   = {~command_i, command_i, ~address_i, address_i};
  assign raw_cnt   = ({1'b0, bit_count_i} > FRAME_CMP) ? FRAME_CNT : BL_W'(bit_count_i);
  assign ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : ticks_q;
  assign bits_dec  = (bits_q != '0) ? bits_q - 1'b1 : bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nirtx_pkg::PH_IDLE;
      ticks_q <= '0;
      shift_q <= '0;
      bits_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    res     = '0;
    unique case (func)
      nirtx_pkg::FUNC_SEND_AC, nirtx_pkg::FUNC_SEND_RAW: begin
        if (phase_q != nirtx_pkg::PH_IDLE || !cfg_i.enabled) begin
          res.rejected = 1'b1;
        end else begin
          phase_d = nirtx_pkg::PH_LEAD_MARK;
          ticks_d = nirtx_pkg::len_of(cfg_i.leader_mark);
          if (func == nirtx_pkg::FUNC_SEND_AC) begin
            shift_d = ac_word;
            bits_d  = FRAME_CNT;
          end else begin
            shift_d = raw_word_i;
            bits_d  = raw_cnt;
          end
        end
      end
      nirtx_pkg::FUNC_TICK: begin
        if (phase_q != nirtx_pkg::PH_IDLE) begin
          res.ir_gate = (phase_q == nirtx_pkg::PH_LEAD_MARK) ||
                        (phase_q == nirtx_pkg::PH_BIT_MARK) ||
                        (phase_q == nirtx_pkg::PH_STOP_MARK);
          ticks_d = ticks_dec;
          if (ticks_dec == '0) begin
            unique case (phase_q)
              nirtx_pkg::PH_LEAD_MARK: begin
                phase_d = nirtx_pkg::PH_LEAD_SPACE;
                ticks_d = nirtx_pkg::len_of(cfg_i.leader_space);
              end
              nirtx_pkg::PH_LEAD_SPACE: begin
                phase_d = (bits_q != '0) ? nirtx_pkg::PH_BIT_MARK : nirtx_pkg::PH_STOP_MARK;
                ticks_d = nirtx_pkg::len_of(cfg_i.bit_mark);
              end
              nirtx_pkg::PH_BIT_MARK: begin
                phase_d = nirtx_pkg::PH_BIT_SPACE;
                ticks_d = nirtx_pkg::len_of(shift_q[0] ? cfg_i.one_space : cfg_i.zero_space);
              end
              nirtx_pkg::PH_BIT_SPACE: begin
                // drop the sent bit and move to the next mark or the stop mark
                shift_d = shift_q >> 1;
                bits_d  = bits_dec;
                phase_d = (bits_dec != '0) ? nirtx_pkg::PH_BIT_MARK : nirtx_pkg::PH_STOP_MARK;
                ticks_d = nirtx_pkg::len_of(cfg_i.bit_mark);
              end
              default: begin
                phase_d = nirtx_pkg::PH_IDLE;
                ticks_d = '0;
                res.frame_done = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.busy = (phase_d != nirtx_pkg::PH_IDLE);
  end

  assign res_o  = res;
  assign busy_o = (phase_q != nirtx_pkg::PH_IDLE);

endmodule

/* hdl/nec_ir_frame_transmitter.sv */
// NEC infrared transmit envelope generator. Each transaction on the input channel is either
// one microsecond tick, a send of address and command (sent as address, ~address, command,
// ~command, LSB first) or a send of a raw word with a bit count. Every input transaction
// yields exactly one result: the carrier gate level for that tick, whether a frame is still
// running, whether this tick ended the stop mark, and whether a send was refused because a
// frame was in progress or the transmitter is disabled. One item is accepted per cycle while
// no result is left waiting: the frame state and the result register both update at the
// accepting edge, and the result is offered in the cycle after. A new item is taken whenever the
// result register is empty or its result is taken in the same cycle; a result left waiting
// holds off the input. Durations are loaded from the APB registers when each phase begins.
module nec_ir_frame_transmitter #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      func_i,
  input  logic [7:0]                      address_i,
  input  logic [7:0]                      command_i,
  input  logic [nirtx_pkg::WORD_W-1:0]    raw_word_i,
  input  logic [nirtx_pkg::CNT_IN_W-1:0]  bit_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            ir_gate_o,
  output logic                            busy_res_o,
  output logic                            frame_done_o,
  output logic                            rejected_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nirtx_pkg::ADDR_W-1:0]    paddr,
  input  logic [nirtx_pkg::DATA_W-1:0]    pwdata,
  output logic [nirtx_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  nirtx_pkg::cfg_t cfg;
  nirtx_pkg::res_t res, res_q;
  logic            advance;
  logic            out_valid_q;
  logic            busy;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;

  nirtx_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nirtx_ctrl #(
    .FRAME_BITS (FRAME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .func_i      (func_i),
    .address_i   (address_i),
    .command_i   (command_i),
    .raw_word_i  (raw_word_i),
    .bit_count_i (bit_count_i),
    .cfg_i       (cfg),
    .res_o       (res),
    .busy_o      (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && !out_ready_i);
    end
  end

  // hold the result until the output transaction completes
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ir_gate_o    = res_q.ir_gate;
  assign busy_res_o   = res_q.busy;
  assign frame_done_o = res_q.frame_done;
  assign rejected_o   = res_q.rejected;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !busy_res_o)
    else $error("frame_done reported while still busy");

  a_busy_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> busy_res_o == busy)
    else $error("busy result disagrees with frame state");

  a_reject_keeps_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && busy && (func_i == nirtx_pkg::FUNC_SEND_AC || func_i == nirtx_pkg::FUNC_SEND_RAW)
    |=> rejected_o && busy)
    else $error("send during a frame not rejected or frame lost");
`endif

endmodule

/* tb/sv/nec_ir_frame_transmitter_checker.sv */
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_checker
  import nirtx_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          address_i,
  input  logic [7:0]          command_i,
  input  logic [WORD_W-1:0]   raw_word_i,
  input  logic [CNT_IN_W-1:0] bit_count_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                ir_gate_i,
  input  logic                busy_res_i,
  input  logic                frame_done_i,
  input  logic                rejected_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [ADDR_W-1:0]   paddr_i,
  input  logic [DATA_W-1:0]   pwdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  cfg_t             tx_cfg;
  phase_e           tx_phase;
  logic [DUR_W-1:0] tx_ticks;
  logic [31:0]      tx_shift;
  int unsigned      tx_bits;
  res_t             results_due[$];
  int               fails = 0;

  function automatic logic [DUR_W-1:0] one_or_more(logic [DUR_W-1:0] v);
    return (v == '0) ? DUR_W'(1) : v;
  endfunction

  function automatic void start_mark();
    tx_phase = (tx_bits > 0) ? PH_BIT_MARK : PH_STOP_MARK;
    tx_ticks = one_or_more(tx_cfg.bit_mark);
  endfunction

  // Advance the envelope by one transaction and return the result it yields.
  function automatic res_t advance_envelope(func_e f, logic [7:0] addr, logic [7:0] cmd,
                                            logic [31:0] word, logic [CNT_IN_W-1:0] cnt);
    res_t r;
    r = '0;
    case (f)
      FUNC_SEND_AC, FUNC_SEND_RAW: begin
        if (tx_phase != PH_IDLE || !tx_cfg.enabled) begin
          r.rejected = 1'b1;
        end else begin
          if (f == FUNC_SEND_AC) begin
            tx_shift = {~cmd, cmd, ~addr, addr};
            tx_bits  = FRAME_BITS;
          end else begin
            tx_shift = word;
            tx_bits  = (cnt > FRAME_BITS) ? FRAME_BITS : cnt;
          end
          tx_phase = PH_LEAD_MARK;
          tx_ticks = one_or_more(tx_cfg.leader_mark);
        end
      end
      FUNC_TICK: begin
        if (tx_phase != PH_IDLE) begin
          r.ir_gate = tx_phase inside {PH_LEAD_MARK, PH_BIT_MARK, PH_STOP_MARK};
          if (tx_ticks != 0) tx_ticks--;
          if (tx_ticks == 0) begin
            case (tx_phase)
              PH_LEAD_MARK: begin
                tx_phase = PH_LEAD_SPACE;
                tx_ticks = one_or_more(tx_cfg.leader_space);
              end
              PH_LEAD_SPACE: start_mark();
              PH_BIT_MARK: begin
                tx_phase = PH_BIT_SPACE;
                tx_ticks = one_or_more(tx_shift[0] ? tx_cfg.one_space : tx_cfg.zero_space);
              end
              PH_BIT_SPACE: begin
                tx_shift = tx_shift >> 1;
                if (tx_bits > 0) tx_bits--;
                start_mark();
              end
              default: begin
                tx_phase     = PH_IDLE;
                tx_ticks     = '0;
                r.frame_done = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    r.busy = (tx_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void compare_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_channels
    res_t want;
    if (!rst_ni) begin
      tx_cfg   = '{enabled: 1'b0, leader_mark: RST_LEADER_MARK,
                   leader_space: RST_LEADER_SPACE, bit_mark: RST_BIT_MARK,
                   zero_space: RST_ZERO_SPACE, one_space: RST_ONE_SPACE};
      tx_phase = PH_IDLE;
      tx_ticks = '0;
      tx_shift = '0;
      tx_bits  = 0;
      results_due.delete();
    end else begin
      // Queue the prediction before popping so a same-cycle result still lines up.
      if (in_valid_i && in_ready_i) begin
        results_due.push_back(advance_envelope(func_e'(func_i), address_i, command_i,
                                               raw_word_i, bit_count_i));
      end
      // A register write lands at this edge, so it applies from the next transaction on.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ADDR_W-1:2]))
          REG_ENABLED:      tx_cfg.enabled      = pwdata_i[0];
          REG_LEADER_MARK:  tx_cfg.leader_mark  = pwdata_i[DUR_W-1:0];
          REG_LEADER_SPACE: tx_cfg.leader_space = pwdata_i[DUR_W-1:0];
          REG_BIT_MARK:     tx_cfg.bit_mark     = pwdata_i[DUR_W-1:0];
          REG_ZERO_SPACE:   tx_cfg.zero_space   = pwdata_i[DUR_W-1:0];
          REG_ONE_SPACE:    tx_cfg.one_space    = pwdata_i[DUR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result transaction with no input transaction pending");
          fails++;
        end else begin
          want = results_due.pop_front();
          compare_field("ir_gate", want.ir_gate, ir_gate_i);
          compare_field("busy_res", want.busy, busy_res_i);
          compare_field("frame_done", want.frame_done, frame_done_i);
          compare_field("rejected", want.rejected, rejected_i);
        end
      end
      fail_count_o <= fails;
      pending_o    <= results_due.size();
    end
  end

endmodule

/* tb/sv/nec_ir_frame_transmitter_tb.sv */
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_tb;
  import nirtx_pkg::*;

  localparam int unsigned FRAME_BITS   = 32;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          PHASE_ITEMS  = 100;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [1:0]          func_i      = FUNC_TICK;
  logic [7:0]          address_i   = '0;
  logic [7:0]          command_i   = '0;
  logic [WORD_W-1:0]   raw_word_i  = '0;
  logic [CNT_IN_W-1:0] bit_count_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                ir_gate_o;
  logic                busy_res_o;
  logic                frame_done_o;
  logic                rejected_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int          fail_count;
  int          pending;
  int unsigned dur_now [1:5];
  int unsigned dur_hi  [1:5];
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;
  int          items_done = 0;
  int          stall_mode = 0;
  int          stall_win  = 0;
  int          stall_step = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nec_ir_frame_transmitter #(
    .FRAME_BITS(FRAME_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .address_i   (address_i),
    .command_i   (command_i),
    .raw_word_i  (raw_word_i),
    .bit_count_i (bit_count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ir_gate_o   (ir_gate_o),
    .busy_res_o  (busy_res_o),
    .frame_done_o(frame_done_o),
    .rejected_o  (rejected_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  nec_ir_frame_transmitter_checker #(
    .FRAME_BITS(FRAME_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .func_i      (func_i),
    .address_i   (address_i),
    .command_i   (command_i),
    .raw_word_i  (raw_word_i),
    .bit_count_i (bit_count_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .ir_gate_i   (ir_gate_o),
    .busy_res_i  (busy_res_o),
    .frame_done_i(frame_done_o),
    .rejected_i  (rejected_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver: switch between always ready, light, periodic and heavy stalls.
  always @(posedge clk_i) begin
    if (stall_win == 0) begin
      stall_mode = $urandom_range(3, 0);
      stall_win  = $urandom_range(200, 20);
    end
    stall_win--;
    stall_step++;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(3, 0) != 0);
      2:       out_ready_i <= ((stall_step % 8) >= 3);
      default: out_ready_i <= ($urandom_range(9, 0) < 3);
    endcase
  end

  task automatic put_item(func_e f, logic [7:0] a, logic [7:0] c, logic [31:0] w,
                          logic [CNT_IN_W-1:0] n);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
      burst_left = $urandom_range(12, 1);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    address_i   <= a;
    command_i   <= c;
    raw_word_i  <= w;
    bit_count_i <= n;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    items_done++;
  endtask

  // Unused fields carry random values on every transaction.
  task automatic put_random(func_e f);
    put_item(f, 8'($urandom), 8'($urandom), $urandom, CNT_IN_W'($urandom));
  endtask

  task automatic tick_n(int n);
    repeat (n) put_random(FUNC_TICK);
  endtask

  // Hold the input channel until every predicted result has been collected.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e r, logic [DUR_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (r != REG_ENABLED) begin
      dur_now[r] = (v == '0) ? 1 : v;
      if (dur_now[r] > dur_hi[r]) dur_hi[r] = dur_now[r];
    end
  endtask

  function automatic int unsigned frame_span(int unsigned nbits);
    int unsigned sp;
    sp = (dur_hi[REG_ZERO_SPACE] > dur_hi[REG_ONE_SPACE]) ? dur_hi[REG_ZERO_SPACE]
                                                          : dur_hi[REG_ONE_SPACE];
    return dur_hi[REG_LEADER_MARK] + dur_hi[REG_LEADER_SPACE]
           + nbits * (dur_hi[REG_BIT_MARK] + sp) + dur_hi[REG_BIT_MARK];
  endfunction

  function automatic logic [DUR_W-1:0] random_duration();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 20) return '0;
    if (pick < 75) return DUR_W'($urandom_range(3, 1));
    return DUR_W'($urandom_range(8, 4));
  endfunction

  // One send followed by enough ticks to finish it, with noise mixed in.
  task automatic run_frame();
    int          kind;
    int          pick;
    int unsigned nbits;
    int unsigned span;
    int unsigned ticks;
    func_e       f;
    logic [CNT_IN_W-1:0] cnt;
    reg_idx_e    r;
    kind = $urandom_range(9, 0);
    cnt  = CNT_IN_W'($urandom_range(6, 0));
    if (kind == 5) cnt = CNT_IN_W'($urandom_range(63, 33));
    else if (kind == 6) cnt = CNT_IN_W'($urandom_range(32, 7));
    f     = (kind >= 7) ? FUNC_SEND_AC : FUNC_SEND_RAW;
    nbits = (f == FUNC_SEND_AC || cnt > FRAME_BITS) ? FRAME_BITS : cnt;
    dur_hi = dur_now;
    put_item(f, 8'($urandom), 8'($urandom), $urandom, cnt);
    span  = frame_span(nbits);
    ticks = 0;
    while (ticks < span + 3) begin
      pick = $urandom_range(99, 0);
      if (pick < 4 && 2 * ticks < span) begin
        put_random(func_e'($urandom_range(2, 1)));
      end else if (pick < 7) begin
        put_random(FUNC_NOP);
      end else if (pick == 7 && 2 * ticks < span) begin
        // Rewrite a register mid-frame; durations apply from the next phase on.
        drain();
        r = reg_idx_e'($urandom_range(5, 0));
        write_reg(r, (r == REG_ENABLED) ? DUR_W'($urandom_range(1, 0)) : random_duration());
        span = frame_span(nbits);
      end else begin
        put_random(FUNC_TICK);
        ticks++;
      end
    end
  endtask

  initial begin : stimulus
    int start;
    dur_now[REG_LEADER_MARK]  = RST_LEADER_MARK;
    dur_now[REG_LEADER_SPACE] = RST_LEADER_SPACE;
    dur_now[REG_BIT_MARK]     = RST_BIT_MARK;
    dur_now[REG_ZERO_SPACE]   = RST_ZERO_SPACE;
    dur_now[REG_ONE_SPACE]    = RST_ONE_SPACE;
    dur_hi = dur_now;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle and disabled behavior straight out of reset.
    put_random(FUNC_TICK);
    put_random(FUNC_NOP);
    put_item(FUNC_SEND_AC, 8'hff, 8'h00, '0, '0);
    put_item(FUNC_SEND_RAW, 8'h00, 8'hff, 32'hffff_ffff, 6'd63);
    drain();
    write_reg(REG_ENABLED, 16'd1);
    write_reg(REG_LEADER_MARK, 16'd2);
    write_reg(REG_LEADER_SPACE, 16'd0);
    write_reg(REG_BIT_MARK, 16'd1);
    write_reg(REG_ZERO_SPACE, 16'd0);
    write_reg(REG_ONE_SPACE, 16'd3);
    // Empty frame: leader straight into the stop mark; sends while busy bounce.
    put_item(FUNC_SEND_RAW, 8'h00, 8'h00, 32'h0, 6'd0);
    put_item(FUNC_SEND_AC, 8'hff, 8'h00, '0, '0);
    put_random(FUNC_NOP);
    tick_n(4);
    put_random(FUNC_TICK);
    // Single one bit with a long space.
    put_item(FUNC_SEND_RAW, 8'h00, 8'h00, 32'h1, 6'd1);
    tick_n(8);

    start = items_done;
    for (int p = 0; items_done - start < RANDOM_ITEMS; p++) begin
      drain();
      gaps_on = (p % 3 != 2);
      for (int i = 1; i <= 5; i++) begin
        write_reg(reg_idx_e'(i), (p == 0) ? '0 : random_duration());
      end
      write_reg(REG_ENABLED, ($urandom_range(9, 0) != 0) ? 16'd1 : 16'd0);
      begin : one_phase
        int phase_start;
        phase_start = items_done;
        while (items_done - phase_start < PHASE_ITEMS) run_frame();
      end
    end

    // Full 16-bit leader mark; other registers swing to the top mid-frame.
    drain();
    gaps_on = 1'b0;
    write_reg(REG_ENABLED, 16'd1);
    write_reg(REG_LEADER_MARK, 16'hffff);
    for (int i = 2; i <= 5; i++) write_reg(reg_idx_e'(i), '0);
    put_item(FUNC_SEND_RAW, 8'h00, 8'h00, $urandom, 6'd2);
    tick_n(40);
    drain();
    for (int i = 2; i <= 5; i++) write_reg(reg_idx_e'(i), 16'hffff);
    tick_n(40);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
